// ===== src/smj_pkg.sv =====
// Shared constants, codes and control structs of the sorted merge join core.
package smj_pkg;

  localparam int unsigned LIST_DEPTH = 1024;
  localparam int unsigned KEY_BITS   = 64;
  localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned OUT_IDX_W  = 10;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned KEY_IN_W   = 64;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_LOAD_A = 2'd1,
    FUNC_LOAD_B = 2'd2,
    FUNC_FETCH  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_PAIR     = 2'd1,
    ST_NO_MORE  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD_A,
    OP_LOAD_B,
    OP_DELIVER,
    OP_DELIVER_NEW,
    OP_STEP,
    OP_INC_A,
    OP_INC_B,
    OP_NO_MORE
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_SCAN_A,
    S_CMP_A,
    S_SCAN_B,
    S_CMP_B,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e  op;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic in_group;
    logic heads_avail;
    logic key_lt;
    logic key_gt;
    logic a_avail;
    logic a_eq;
    logic b_avail;
    logic b_eq;
    logic slot_free;
  } dp_stat_t;

endpackage

// ===== src/smj_ctrl.sv =====
// Controller state machine that sequences the merge walk and the group scans.
module smj_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [smj_pkg::FUNC_W-1:0]  func_i,
  input  smj_pkg::dp_stat_t           stat_i,
  output smj_pkg::dp_cmd_t            cmd_o
);

  smj_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smj_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == smj_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = smj_pkg::OP_NONE;
    cmd_o.push  = 1'b0;
    case (state_q)
      smj_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = smj_pkg::S_DONE;
          case (smj_pkg::func_e'(func_i))
            smj_pkg::FUNC_CLEAR:  cmd_o.op = smj_pkg::OP_CLEAR;
            smj_pkg::FUNC_LOAD_A: cmd_o.op = smj_pkg::OP_LOAD_A;
            smj_pkg::FUNC_LOAD_B: cmd_o.op = smj_pkg::OP_LOAD_B;
            smj_pkg::FUNC_FETCH: begin
              if (stat_i.in_group) begin
                cmd_o.op = smj_pkg::OP_DELIVER;
              end else begin
                state_d = smj_pkg::S_SEARCH;
              end
            end
            default: cmd_o.op = smj_pkg::OP_NONE;
          endcase
        end
      end
      smj_pkg::S_SEARCH: begin
        // The memories read the head positions every cycle; data is ready in S_CMP.
        if (stat_i.heads_avail) begin
          state_d = smj_pkg::S_CMP;
        end else begin
          cmd_o.op = smj_pkg::OP_NO_MORE;
          state_d  = smj_pkg::S_DONE;
        end
      end
      smj_pkg::S_CMP: begin
        cmd_o.op = smj_pkg::OP_STEP;
        if (stat_i.key_lt || stat_i.key_gt) begin
          state_d = smj_pkg::S_SEARCH;
        end else begin
          state_d = smj_pkg::S_SCAN_A;
        end
      end
      smj_pkg::S_SCAN_A: begin
        if (stat_i.a_avail) begin
          state_d = smj_pkg::S_CMP_A;
        end else begin
          state_d = smj_pkg::S_SCAN_B;
        end
      end
      smj_pkg::S_CMP_A: begin
        if (stat_i.a_eq) begin
          cmd_o.op = smj_pkg::OP_INC_A;
          state_d  = smj_pkg::S_SCAN_A;
        end else begin
          state_d = smj_pkg::S_SCAN_B;
        end
      end
      smj_pkg::S_SCAN_B: begin
        if (stat_i.b_avail) begin
          state_d = smj_pkg::S_CMP_B;
        end else begin
          cmd_o.op = smj_pkg::OP_DELIVER_NEW;
          state_d  = smj_pkg::S_DONE;
        end
      end
      smj_pkg::S_CMP_B: begin
        if (stat_i.b_eq) begin
          cmd_o.op = smj_pkg::OP_INC_B;
          state_d  = smj_pkg::S_SCAN_B;
        end else begin
          cmd_o.op = smj_pkg::OP_DELIVER_NEW;
          state_d  = smj_pkg::S_DONE;
        end
      end
      smj_pkg::S_DONE: begin
        if (stat_i.slot_free) begin
          cmd_o.push = 1'b1;
          state_d    = smj_pkg::S_IDLE;
        end
      end
      default: state_d = smj_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== src/smj_dpath.sv =====
// Datapath: key memories, walk pointers, group ranges, result and output registers.
module smj_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  smj_pkg::dp_cmd_t                cmd_i,
  output smj_pkg::dp_stat_t               stat_o,
  input  logic [smj_pkg::KEY_IN_W-1:0]    key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [smj_pkg::STATUS_W-1:0]    out_status_o,
  output logic [smj_pkg::OUT_IDX_W-1:0]   out_index_a_o,
  output logic [smj_pkg::OUT_IDX_W-1:0]   out_index_b_o
);

  localparam int unsigned CW = smj_pkg::CNT_W;
  localparam int unsigned IW = smj_pkg::IDX_W;
  localparam int unsigned KW = smj_pkg::KEY_BITS;
  localparam int unsigned OW = smj_pkg::OUT_IDX_W;

  logic [KW-1:0] mem_a [smj_pkg::LIST_DEPTH];
  logic [KW-1:0] mem_b [smj_pkg::LIST_DEPTH];
  logic [KW-1:0] rd_a_q, rd_b_q;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] gas_q, gas_d, gae_q, gae_d, gbs_q, gbs_d, gbe_q, gbe_d;
  logic [CW-1:0] inner_a_q, inner_a_d, inner_b_q, inner_b_d;
  logic          in_group_q, in_group_d;
  logic [KW-1:0] kref_q, kref_d;

  logic [smj_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [OW-1:0]                res_a_q, res_a_d, res_b_q, res_b_d;

  logic                         out_valid_q, out_valid_d;
  logic [smj_pkg::STATUS_W-1:0] out_status_q;
  logic [OW-1:0]                out_a_q, out_b_q;

  logic          full_a, full_b, do_deliver, is_new;
  logic [CW-1:0] cur_a, cur_b, nxt_a, nxt_b;

  assign full_a = (cnt_a_q >= CW'(smj_pkg::LIST_DEPTH));
  assign full_b = (cnt_b_q >= CW'(smj_pkg::LIST_DEPTH));

  // Both memories are read at the current walk ends in every cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == smj_pkg::OP_LOAD_A && !full_a) begin
      mem_a[cnt_a_q[IW-1:0]] <= key_i[KW-1:0];
    end
    if (cmd_i.op == smj_pkg::OP_LOAD_B && !full_b) begin
      mem_b[cnt_b_q[IW-1:0]] <= key_i[KW-1:0];
    end
    rd_a_q <= mem_a[gae_q[IW-1:0]];
    rd_b_q <= mem_b[gbe_q[IW-1:0]];
  end

  assign is_new     = (cmd_i.op == smj_pkg::OP_DELIVER_NEW);
  assign do_deliver = is_new || (cmd_i.op == smj_pkg::OP_DELIVER);
  assign cur_a      = is_new ? gas_q : inner_a_q;
  assign cur_b      = is_new ? gbs_q : inner_b_q;
  assign nxt_a      = cur_a + CW'(1);
  assign nxt_b      = cur_b + CW'(1);

  always_comb begin
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    gas_d        = gas_q;
    gae_d        = gae_q;
    gbs_d        = gbs_q;
    gbe_d        = gbe_q;
    inner_a_d    = inner_a_q;
    inner_b_d    = inner_b_q;
    in_group_d   = in_group_q;
    kref_d       = kref_q;
    res_status_d = res_status_q;
    res_a_d      = res_a_q;
    res_b_d      = res_b_q;

    if (cmd_i.op == smj_pkg::OP_CLEAR || cmd_i.op == smj_pkg::OP_LOAD_A ||
        cmd_i.op == smj_pkg::OP_LOAD_B) begin
      gas_d        = '0;
      gae_d        = '0;
      gbs_d        = '0;
      gbe_d        = '0;
      inner_a_d    = '0;
      inner_b_d    = '0;
      in_group_d   = 1'b0;
      res_status_d = smj_pkg::ST_ACCEPTED;
      res_a_d      = '0;
      res_b_d      = '0;
    end

    if (do_deliver) begin
      res_status_d = smj_pkg::ST_PAIR;
      res_a_d      = cur_a[OW-1:0];
      res_b_d      = cur_b[OW-1:0];
      if (nxt_b >= gbe_q) begin
        inner_b_d  = gbs_q;
        inner_a_d  = nxt_a;
        in_group_d = (nxt_a < gae_q);
      end else begin
        inner_b_d  = nxt_b;
        inner_a_d  = cur_a;
        in_group_d = 1'b1;
      end
    end

    case (cmd_i.op)
      smj_pkg::OP_CLEAR: begin
        cnt_a_d = '0;
        cnt_b_d = '0;
      end
      smj_pkg::OP_LOAD_A: begin
        if (full_a) begin
          res_status_d = smj_pkg::ST_FULL;
        end else begin
          cnt_a_d = cnt_a_q + CW'(1);
        end
      end
      smj_pkg::OP_LOAD_B: begin
        if (full_b) begin
          res_status_d = smj_pkg::ST_FULL;
        end else begin
          cnt_b_d = cnt_b_q + CW'(1);
        end
      end
      smj_pkg::OP_STEP: begin
        if (rd_a_q < rd_b_q) begin
          gae_d = gae_q + CW'(1);
        end else if (rd_a_q > rd_b_q) begin
          gbe_d = gbe_q + CW'(1);
        end else begin
          // Head keys match: open a group and scan both lists past it.
          gas_d  = gae_q;
          gbs_d  = gbe_q;
          kref_d = rd_a_q;
          gae_d  = gae_q + CW'(1);
          gbe_d  = gbe_q + CW'(1);
        end
      end
      smj_pkg::OP_INC_A: gae_d = gae_q + CW'(1);
      smj_pkg::OP_INC_B: gbe_d = gbe_q + CW'(1);
      smj_pkg::OP_NO_MORE: begin
        res_status_d = smj_pkg::ST_NO_MORE;
        res_a_d      = '0;
        res_b_d      = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      gas_q      <= '0;
      gae_q      <= '0;
      gbs_q      <= '0;
      gbe_q      <= '0;
      inner_a_q  <= '0;
      inner_b_q  <= '0;
      in_group_q <= 1'b0;
    end else begin
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      gas_q      <= gas_d;
      gae_q      <= gae_d;
      gbs_q      <= gbs_d;
      gbe_q      <= gbe_d;
      inner_a_q  <= inner_a_d;
      inner_b_q  <= inner_b_d;
      in_group_q <= in_group_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kref_q       <= kref_d;
    res_status_q <= res_status_d;
    res_a_q      <= res_a_d;
    res_b_q      <= res_b_d;
  end

  // Output register: a new word may replace one that is taken in the same cycle.
  assign out_valid_d = cmd_i.push || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_status_q <= res_status_q;
      out_a_q      <= res_a_q;
      out_b_q      <= res_b_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_index_a_o = out_a_q;
  assign out_index_b_o = out_b_q;

  assign stat_o.in_group    = in_group_q;
  assign stat_o.heads_avail = (gae_q < cnt_a_q) && (gbe_q < cnt_b_q);
  assign stat_o.key_lt      = (rd_a_q < rd_b_q);
  assign stat_o.key_gt      = (rd_a_q > rd_b_q);
  assign stat_o.a_avail     = (gae_q < cnt_a_q);
  assign stat_o.a_eq        = (rd_a_q == kref_q);
  assign stat_o.b_avail     = (gbe_q < cnt_b_q);
  assign stat_o.b_eq        = (rd_b_q == kref_q);
  assign stat_o.slot_free   = !out_valid_q || out_ready_i;

endmodule

// ===== src/sorted_merge_join_pairs_core.sv =====
// Top level of the sorted merge join core: stream ports, controller and datapath.
// Clear, load and a fetch inside an open group go from S_IDLE to S_DONE, which pushes the result.
// A fetch that searches passes S_SEARCH and S_CMP for each head compare of the merge walk, scans
// each list past the group end in S_SCAN_A/S_CMP_A and S_SCAN_B/S_CMP_B, and ends in S_DONE.
// One word is worked on at a time; the next is taken once the result is queued.
// Reset (asynchronous, active low) empties both lists and restarts the walk; key memories
// are not cleared and need no clearing pass.
module sorted_merge_join_pairs_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] key
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] index_a, [19:10] index_b, [23:20] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  smj_pkg::dp_cmd_t  cmd;
  smj_pkg::dp_stat_t stat;

  logic [smj_pkg::OUT_IDX_W-1:0] index_a, index_b;

  smj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  smj_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .key_i         (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (m_axis_tuser),
    .out_index_a_o (index_a),
    .out_index_b_o (index_b)
  );

  assign m_axis_tdata = {4'b0000, index_b, index_a};

endmodule

// ===== bench/tb.sv =====
// Testbench for sorted_merge_join_pairs_core: stream stimulus with a self-checking join predictor.
module tb;
  import smj_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;    // [63:0] key
  logic [1:0]  s_axis_tuser;    // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;    // [9:0] index_a, [19:10] index_b, [23:20] zero
  logic [1:0]  m_axis_tuser;    // [1:0] status

  typedef struct packed {
    status_e                status;
    logic [OUT_IDX_W-1:0]   idx_a;
    logic [OUT_IDX_W-1:0]   idx_b;
  } join_result_t;

  // Predicts the join walk word by word and holds the results still due from the block.
  class merge_join_scoreboard;
    logic [63:0]  keys_a[LIST_DEPTH];
    logic [63:0]  keys_b[LIST_DEPTH];
    int unsigned  n_a, n_b;
    int unsigned  grp_a_lo, grp_a_hi, grp_b_lo, grp_b_hi;
    int unsigned  cur_a, cur_b;
    bit           grouped;
    join_result_t pending_results[$];
    int unsigned  mismatches;

    function new();
      n_a = 0;
      n_b = 0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      grp_a_lo = 0;
      grp_a_hi = 0;
      grp_b_lo = 0;
      grp_b_hi = 0;
      cur_a = 0;
      cur_b = 0;
      grouped = 0;
    endfunction

    // Hands out the current pair and steps B inside A across the open group.
    function join_result_t emit_pair();
      join_result_t r;
      r.status = ST_PAIR;
      r.idx_a = OUT_IDX_W'(cur_a);
      r.idx_b = OUT_IDX_W'(cur_b);
      cur_b++;
      if (cur_b >= grp_b_hi) begin
        cur_b = grp_b_lo;
        cur_a++;
        if (cur_a >= grp_a_hi) grouped = 0;
      end
      return r;
    endfunction

    function join_result_t fetch_pair();
      int unsigned  ia;
      int unsigned  ib;
      join_result_t r;
      if (grouped) return emit_pair();
      ia = grp_a_hi;
      ib = grp_b_hi;
      while (ia < n_a && ib < n_b) begin
        if (keys_a[ia] < keys_b[ib]) begin
          ia++;
        end else if (keys_a[ia] > keys_b[ib]) begin
          ib++;
        end else begin
          grp_a_lo = ia;
          grp_b_lo = ib;
          ia++;
          ib++;
          while (ia < n_a && keys_a[ia] == keys_a[ia-1]) ia++;
          while (ib < n_b && keys_b[ib] == keys_b[ib-1]) ib++;
          grp_a_hi = ia;
          grp_b_hi = ib;
          cur_a = grp_a_lo;
          cur_b = grp_b_lo;
          grouped = 1;
          return emit_pair();
        end
      end
      // Without a match the end markers record where the next search resumes.
      grp_a_hi = ia;
      grp_b_hi = ib;
      r = '0;
      r.status = ST_NO_MORE;
      return r;
    endfunction

    function status_e note_word(func_e f, logic [63:0] k);
      join_result_t r;
      r = '0;
      r.status = ST_ACCEPTED;
      case (f)
        FUNC_CLEAR: begin
          n_a = 0;
          n_b = 0;
          restart();
        end
        FUNC_LOAD_A: begin
          restart();
          if (n_a >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            keys_a[n_a] = k;
            n_a++;
          end
        end
        FUNC_LOAD_B: begin
          restart();
          if (n_b >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            keys_b[n_b] = k;
            n_b++;
          end
        end
        default: r = fetch_pair();
      endcase
      pending_results.push_back(r);
      return r.status;
    endfunction

    function void check_word(status_e st, logic [OUT_IDX_W-1:0] ia, logic [OUT_IDX_W-1:0] ib);
      join_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result status %0d a %0d b %0d", st, ia, ib);
        return;
      end
      want = pending_results.pop_front();
      if (want.status !== st || want.idx_a !== ia || want.idx_b !== ib) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch expected status %0d a %0d b %0d, got status %0d a %0d b %0d",
                   want.status, want.idx_a, want.idx_b, st, ia, ib);
      end
    endfunction
  endclass

  merge_join_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  bit hold_request;
  int hold_left;

  sorted_merge_join_pairs_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // Result side: checks every accepted word and stalls at random or for a long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(status_e'(m_axis_tuser), m_axis_tdata[9:0], m_axis_tdata[19:10]);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(input func_e f, input logic [63:0] k, output status_e st);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= k;
    s_axis_tuser <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    st = sb.note_word(f, k);
    items_sent++;
  endtask

  // Ascending keys with frequent repeats so that equal-key groups form on both sides.
  task automatic build_sorted(ref logic [63:0] keys[$], input int n, input logic [63:0] start);
    logic [63:0] k;
    int gap;
    keys.delete();
    k = start;
    repeat (n) begin
      keys.push_back(k);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 3);
      if (k > ~64'd0 - gap) k = ~64'd0;
      else k = k + gap;
    end
  endtask

  task automatic run_join(input int na, input int nb, input bit do_clear, input bit interrupt);
    logic [63:0] ka[$];
    logic [63:0] kb[$];
    logic [63:0] start;
    status_e st;
    int fetches;
    case ($urandom_range(9))
      0: start = 64'd0;
      1: start = ~64'd0 - $urandom_range(40);
      default: start = {$urandom, $urandom};
    endcase
    build_sorted(ka, na, start);
    build_sorted(kb, nb, start + $urandom_range(2));
    if (do_clear) send_word(FUNC_CLEAR, {$urandom, $urandom}, st);
    if ($urandom_range(1) == 0) begin
      foreach (ka[i]) send_word(FUNC_LOAD_A, ka[i], st);
      foreach (kb[i]) send_word(FUNC_LOAD_B, kb[i], st);
    end else begin
      while (ka.size() > 0 || kb.size() > 0) begin
        if (kb.size() == 0 || (ka.size() > 0 && $urandom_range(1) == 0))
          send_word(FUNC_LOAD_A, ka.pop_front(), st);
        else
          send_word(FUNC_LOAD_B, kb.pop_front(), st);
      end
    end
    fetches = 0;
    do begin
      // A load in the middle of the walk sends it back to the first positions.
      if (interrupt && $urandom_range(19) == 0)
        send_word(($urandom_range(1) == 0) ? FUNC_LOAD_A : FUNC_LOAD_B,
                  start + $urandom_range(60), st);
      send_word(FUNC_FETCH, {$urandom, $urandom}, st);
      fetches++;
    end while (st != ST_NO_MORE && fetches < 120);
    repeat ($urandom_range(2)) send_word(FUNC_FETCH, {$urandom, $urandom}, st);
  endtask

  initial begin
    status_e st;
    logic [63:0] start;
    int random_base;
    int budget;
    int r;
    int progress;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = FUNC_CLEAR;
    m_axis_tready = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    items_sent = 0;
    send_idle_pct = 22;
    recv_idle_pct = 46;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fetch on empty lists, extreme keys, groups on both sides, an unsorted list.
    send_word(FUNC_FETCH, 64'd0, st);
    send_word(FUNC_LOAD_A, 64'd0, st);
    send_word(FUNC_LOAD_A, 64'd0, st);
    send_word(FUNC_LOAD_A, ~64'd0, st);
    send_word(FUNC_LOAD_B, 64'd0, st);
    send_word(FUNC_LOAD_B, ~64'd0, st);
    send_word(FUNC_LOAD_B, ~64'd0, st);
    repeat (6) send_word(FUNC_FETCH, ~64'd0, st);
    send_word(FUNC_LOAD_B, 64'd5, st);
    repeat (6) send_word(FUNC_FETCH, 64'd0, st);
    send_word(FUNC_CLEAR, ~64'd0, st);
    repeat (2) send_word(FUNC_FETCH, 64'd0, st);

    // Capacity: fill list A past the top and give B a short list whose tail matches the
    // last groups of A, so the first fetch walks A up to its last groups and the pairs carry the
    // largest A indices.
    start = {1'b0, 31'($urandom), $urandom};
    for (int i = 0; i <= LIST_DEPTH; i++) begin
      if (i == 100) hold_request = 1'b1;
      send_word(FUNC_LOAD_A,
                (i < 1000) ? start + 2 * i : start + 4000 + (i - 1000) / 4, st);
    end
    for (int i = 0; i < 40; i++)
      send_word(FUNC_LOAD_B,
                (i < 24) ? start + 2 * i + 1 : start + 4002 + (i - 24) / 4, st);
    send_word(FUNC_LOAD_A, {$urandom, $urandom}, st);
    do send_word(FUNC_FETCH, {$urandom, $urandom}, st); while (st != ST_NO_MORE);
    send_word(FUNC_FETCH, 64'd0, st);

    random_base = items_sent;
    budget = (1650 > random_base + 300) ? 1650 - random_base : 300;
    progress = 0;
    while (progress < budget) begin
      if (progress < budget / 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 46;
      end else if (progress < 2 * budget / 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 22;
      end else begin
        if (send_idle_pct != 0) hold_request = 1'b1;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      r = $urandom_range(99);
      if (r < 70) begin
        run_join($urandom_range(24), $urandom_range(24), $urandom_range(9) != 0,
                 $urandom_range(3) == 0);
      end else if (r < 85) begin
        // Unsorted keys drawn from a narrow range, without a clear first.
        start = {$urandom, $urandom};
        repeat ($urandom_range(4, 16))
          send_word(($urandom_range(1) == 0) ? FUNC_LOAD_A : FUNC_LOAD_B,
                    start + $urandom_range(5), st);
        repeat ($urandom_range(2, 10)) send_word(FUNC_FETCH, {$urandom, $urandom}, st);
      end else begin
        repeat ($urandom_range(1, 8))
          send_word(func_e'($urandom_range(3)), {$urandom, $urandom}, st);
      end
      progress = items_sent - random_base;
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
